### rtl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg: shared types and constants
// grid path search state codes, heuristic table and helpers
// ----------------------------------------------------------------------------
package gaps_pkg;

	localparam int CELL_W  = 6;
	localparam int CELLS   = 64;
	localparam int G_W     = 7;
	localparam int LEN_W   = 7;
	localparam int BID_W   = 14;
	localparam int COST_W  = 8;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_EXPAND,
		ST_NBR,
		ST_RELAX,
		ST_TRACE,
		ST_EMIT,
		ST_FAIL,
		ST_WAIT
	} state_t;

	// floor(sqrt(dr^2 + dc^2)) for dr, dc in 0..7
	function automatic logic [3:0] heur(input logic [2:0] dr, input logic [2:0] dc);
		logic [6:0] n;
		logic [3:0] r;
		n = (7'(dr) * 7'(dr)) + (7'(dc) * 7'(dc));
		r = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (7'(k * k) <= n) r = 4'(k);
		end
		return r;
	endfunction

	function automatic logic [2:0] absdiff(input logic [2:0] a, input logic [2:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

### rtl/grid_astar_path_search_unit.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit: 4-connected grid A* path search
// loads obstacle bits, searches start to goal and streams the path out
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)                    | tuser
// s_axis  | in  | row, col, obstacle, goal_row, goal_col           | operation
// m_axis  | out | path_row, path_col, found, path_length, bid      | - (tlast = last)
// cfg     | in  | movement_cost                                    | -
// a load writes one obstacle bit and tready stays high; a search scans all 64 cells
// per expansion (one registered g read and one shared f adder and compare
// a cycle, then a pipeline drain), then pick, expand and a neighbor read
// and relax per move; at the goal the trace walks the parents back to the
// start, then emit streams each path cell and a wait state returns to idle
// s_axis_tready is low while a search runs or results are pending
// results stall freely on m_axis_tready; the output register holds them
// arst_n clears control, open and closed marks, parent marks and the obstacle map
module grid_astar_path_search_unit #(
	parameter int GRID_ROWS = 8,
	parameter int GRID_COLS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // row, col, obstacle, goal_row, goal_col
	input  logic        s_axis_tuser,   // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // path_row, path_col, found, path_length, bid
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	localparam int CW = gaps_pkg::CELL_W;
	localparam int GW = gaps_pkg::G_W;

	gaps_pkg::state_t state_q, state_d;

	logic [7:0]    cost_q;
	logic [63:0]   obst_q, open_q, closed_q, haspar_q;
	logic [GW-1:0] g_mem [64];
	logic [CW-1:0] par_mem [64];
	logic [CW-1:0] stk_mem [64];

	logic [2:0]    gr_q, gc_q;
	logic [CW:0]   scan_q;        // counter including 64
	logic          have_q;
	logic [CW-1:0] best_q;
	logic [7:0]    bestf_q;
	logic [GW-1:0] bestg_q;
	logic [1:0]    mv_q;
	logic [CW-1:0] cur_q;
	logic [CW:0]   n_q, k_q;

	// scan pipeline stage: registered g read of the scanned cell
	logic          pend_s1, hit_s1;
	logic [CW-1:0] idx_s1;
	logic [GW-1:0] g_s1;
	// registered g of the current neighbor
	logic [GW-1:0] gnb_q;

	// output register
	logic          ov_q, olast_q, ofound_q;
	logic [2:0]    orow_q, ocol_q;
	logic [6:0]    olen_q;
	logic [13:0]   obid_q;

	wire accept  = s_axis_tvalid && s_axis_tready;
	wire op      = s_axis_tuser;
	wire [2:0] ir  = s_axis_tdata[2:0];
	wire [2:0] ic  = s_axis_tdata[5:3];
	wire iobs    = s_axis_tdata[6];
	wire [2:0] igr = s_axis_tdata[9:7];
	wire [2:0] igc = s_axis_tdata[12:10];
	wire out_free = !ov_q || m_axis_tready;
	wire out_load = ((state_q == gaps_pkg::ST_EMIT) || (state_q == gaps_pkg::ST_FAIL)) &&
		out_free;

	assign s_axis_tready = (state_q == gaps_pkg::ST_IDLE) && !ov_q;

	// scan address of this cycle
	wire [CW-1:0] sc_i = scan_q[CW-1:0];
	wire sc_in = (32'(sc_i[5:3]) < GRID_ROWS) && (32'(sc_i[2:0]) < GRID_COLS);

	// shared f unit: registered g of scanned cell plus table heuristic
	wire [2:0] sr3 = idx_s1[5:3];
	wire [2:0] scc = idx_s1[2:0];
	wire [7:0] sc_f = 8'(g_s1) + 8'(gaps_pkg::heur(gaps_pkg::absdiff(sr3, gr_q),
		gaps_pkg::absdiff(scc, gc_q)));

	// neighbor of best for current move
	logic [2:0] br, bc;
	logic [3:0] nr, nc;
	assign br = best_q[5:3];
	assign bc = best_q[2:0];
	always_comb begin
		nr = {1'b0, br};
		nc = {1'b0, bc};
		case (mv_q)
			2'd0: nc = {1'b0, bc} - 4'd1;
			2'd1: nc = {1'b0, bc} + 4'd1;
			2'd2: nr = {1'b0, br} - 4'd1;
			2'd3: nr = {1'b0, br} + 4'd1;
			default: nr = {1'b0, br};
		endcase
	end
	wire nb_ok = !nr[3] && !nc[3] && (32'(nr) < GRID_ROWS) && (32'(nc) < GRID_COLS);
	wire [CW-1:0] nj = {nr[2:0], nc[2:0]};
	wire [GW-1:0] ng = bestg_q + 7'd1;
	wire nb_upd = nb_ok && !obst_q[nj] && !closed_q[nj] && (!open_q[nj] || ng < gnb_q);

	wire is_goal = (br == gr_q) && (bc == gc_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			gaps_pkg::ST_IDLE: if (accept && op == gaps_pkg::OP_SEARCH) begin
				if (32'(ir) >= GRID_ROWS || 32'(ic) >= GRID_COLS ||
				    32'(igr) >= GRID_ROWS || 32'(igc) >= GRID_COLS)
					state_d = gaps_pkg::ST_FAIL;
				else state_d = gaps_pkg::ST_SCAN;
			end
			gaps_pkg::ST_SCAN:   if (scan_q[CW] && !pend_s1) state_d = gaps_pkg::ST_PICK;
			gaps_pkg::ST_PICK: begin
				if (!have_q) state_d = gaps_pkg::ST_FAIL;
				else if (is_goal) state_d = gaps_pkg::ST_TRACE;
				else state_d = gaps_pkg::ST_EXPAND;
			end
			gaps_pkg::ST_EXPAND: state_d = gaps_pkg::ST_NBR;
			gaps_pkg::ST_NBR:    state_d = gaps_pkg::ST_RELAX;
			gaps_pkg::ST_RELAX: begin
				if (mv_q == 2'd3) state_d = gaps_pkg::ST_SCAN;
				else state_d = gaps_pkg::ST_NBR;
			end
			gaps_pkg::ST_TRACE:  if (!haspar_q[cur_q]) state_d = gaps_pkg::ST_EMIT;
			gaps_pkg::ST_EMIT:   if (out_free && k_q == n_q - 7'd1) state_d = gaps_pkg::ST_WAIT;
			gaps_pkg::ST_FAIL:   if (out_free) state_d = gaps_pkg::ST_WAIT;
			gaps_pkg::ST_WAIT:   state_d = gaps_pkg::ST_IDLE;
			default: state_d = gaps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gaps_pkg::ST_IDLE;
			cost_q   <= 8'd1;
			obst_q   <= '0;
			open_q   <= '0;
			closed_q <= '0;
			haspar_q <= '0;
			ov_q     <= 1'b0;
			scan_q   <= '0;
			have_q   <= 1'b0;
			mv_q     <= '0;
			n_q      <= '0;
			k_q      <= '0;
			pend_s1  <= 1'b0;
			hit_s1   <= 1'b0;
			idx_s1   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) cost_q <= cfg_wr_data;
			// output register: load a new result or release the taken one
			if (out_load) ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
			case (state_q)
				gaps_pkg::ST_IDLE: if (accept) begin
					if (op == gaps_pkg::OP_LOAD) begin
						if (32'(ir) < GRID_ROWS && 32'(ic) < GRID_COLS)
							obst_q[{ir, ic}] <= iobs;
					end else begin
						gr_q <= igr;
						gc_q <= igc;
						// only the start cell is open
						open_q <= 64'd1 << {ir, ic};
						closed_q <= '0;
						haspar_q <= '0;
						scan_q <= '0;
						have_q <= 1'b0;
					end
				end
				gaps_pkg::ST_SCAN: begin
					pend_s1 <= !scan_q[CW];
					hit_s1  <= !scan_q[CW] && sc_in && open_q[sc_i];
					idx_s1  <= sc_i;
					if (!scan_q[CW]) scan_q <= scan_q + 7'd1;
					if (hit_s1 && (!have_q || sc_f < bestf_q)) begin
						have_q  <= 1'b1;
						best_q  <= idx_s1;
						bestf_q <= sc_f;
						bestg_q <= g_s1;
					end
				end
				gaps_pkg::ST_PICK: begin
					cur_q <= best_q;
					n_q   <= '0;
				end
				gaps_pkg::ST_EXPAND: begin
					open_q[best_q]   <= 1'b0;
					closed_q[best_q] <= 1'b1;
					mv_q <= '0;
				end
				gaps_pkg::ST_RELAX: begin
					mv_q <= mv_q + 2'd1;
					if (nb_upd) begin
						open_q[nj]   <= 1'b1;
						haspar_q[nj] <= 1'b1;
					end
					if (mv_q == 2'd3) begin
						scan_q <= '0;
						have_q <= 1'b0;
					end
				end
				gaps_pkg::ST_TRACE: begin
					n_q   <= n_q + 7'd1;
					cur_q <= par_mem[cur_q];
					k_q   <= '0;
				end
				gaps_pkg::ST_EMIT: if (out_free) begin
					k_q  <= k_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	// stored per-cell data and output payload
	wire [CW:0] pos = n_q - 7'd1 - k_q;
	wire [13:0] bid_full = 14'(n_q) * 14'(cost_q);
	always_ff @(posedge clk) begin
		if (state_q == gaps_pkg::ST_IDLE && accept) g_mem[{ir, ic}] <= '0;
		if (state_q == gaps_pkg::ST_SCAN) g_s1 <= g_mem[sc_i];
		if (state_q == gaps_pkg::ST_NBR) gnb_q <= g_mem[nj];
		if (state_q == gaps_pkg::ST_RELAX && nb_upd) begin
			g_mem[nj]   <= ng;
			par_mem[nj] <= best_q;
		end
		if (state_q == gaps_pkg::ST_TRACE) stk_mem[n_q[CW-1:0]] <= cur_q;
		if (state_q == gaps_pkg::ST_EMIT && out_free) begin
			orow_q   <= stk_mem[pos[CW-1:0]][5:3];
			ocol_q   <= stk_mem[pos[CW-1:0]][2:0];
			ofound_q <= 1'b1;
			olast_q  <= (k_q == n_q - 7'd1);
			olen_q   <= (k_q == n_q - 7'd1) ? n_q : 7'd0;
			obid_q   <= (k_q == n_q - 7'd1) ? bid_full : 14'd0;
		end
		if (state_q == gaps_pkg::ST_FAIL && out_free) begin
			orow_q <= '0; ocol_q <= '0; ofound_q <= 1'b0;
			olast_q <= 1'b1; olen_q <= '0; obid_q <= '0;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {4'd0, obid_q, olen_q, ofound_q, ocol_q, orow_q};

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gaps_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !m_axis_tready |=> ov_q) else $error("result dropped");
	a_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gaps_pkg::ST_EXPAND) |=> closed_q[$past(best_q)]) else $error("not closed");

endmodule

### tb/grid_astar_path_search_unit_test.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit_test: path search stream testbench
// loads obstacle grids, runs searches and compares every streamed path cell
// with a behavioral A* predictor under random idling and back pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_astar_path_search_unit_test;

	// one streamed path cell
	typedef struct packed {
		logic [2:0]  path_row;
		logic [2:0]  path_col;
		logic        found;
		logic        last;
		logic [6:0]  path_length;
		logic [13:0] bid;
	} path_cell_t;

	// scoreboard: behavioral A* plus the queue of pending path cells
	class path_scoreboard;
		bit          blocked[64];
		logic [7:0]  move_cost;
		path_cell_t  pending_cells[$];
		int          mismatches;

		function void clear();
			foreach (blocked[i]) blocked[i] = 0;
			move_cost = 8'd1;
			pending_cells.delete();
			mismatches = 0;
		endfunction

		function int dist_est(int r, int c, int gr, int gc);
			int n;
			int k;
			n = (r - gr) * (r - gr) + (c - gc) * (c - gc);
			k = 0;
			while ((k + 1) * (k + 1) <= n) k++;
			return k;
		endfunction

		function void add_cell(path_cell_t p);
			pending_cells = {pending_cells, p};
		endfunction

		function void push_not_found();
			path_cell_t p;
			p = '0;
			p.last = 1'b1;
			add_cell(p);
		endfunction

		// note one accepted input transaction
		function void note_input(logic op, logic [15:0] d);
			int sr, sc, gr, gc;
			bit opened[64];
			bit closed[64];
			int g[64];
			int par[64];
			int best, best_f, f, cr, cc, nr, nc, j, ng, n;
			int trail[$];
			int dr[4];
			int dc[4];
			path_cell_t p;
			dr = '{0, 0, -1, 1};
			dc = '{-1, 1, 0, 0};
			sr = int'(d[2:0]); sc = int'(d[5:3]); gr = int'(d[9:7]); gc = int'(d[12:10]);
			if (op == gaps_pkg::OP_LOAD) begin
				blocked[sr * 8 + sc] = d[6];
				return;
			end
			foreach (par[i]) begin
				par[i] = -1; opened[i] = 0; closed[i] = 0; g[i] = 0;
			end
			opened[sr * 8 + sc] = 1;
			forever begin
				best = -1; best_f = 0;
				for (int i = 0; i < 64; i++) begin
					if (!opened[i]) continue;
					f = g[i] + dist_est(i / 8, i % 8, gr, gc);
					if (best < 0 || f < best_f) begin
						best = i; best_f = f;
					end
				end
				if (best < 0) break;
				cr = best / 8; cc = best % 8;
				if (cr == gr && cc == gc) begin
					// walk parents back to the start
					for (int cur = best; cur >= 0; cur = par[cur]) trail.push_front(cur);
					n = trail.size();
					foreach (trail[k]) begin
						p = '0;
						p.path_row = 3'(trail[k] / 8);
						p.path_col = 3'(trail[k] % 8);
						p.found = 1'b1;
						if (k == n - 1) begin
							p.last = 1'b1;
							p.path_length = 7'(n);
							p.bid = 14'(n * move_cost);
						end
						add_cell(p);
					end
					return;
				end
				opened[best] = 0; closed[best] = 1;
				ng = g[best] + 1;
				for (int m = 0; m < 4; m++) begin
					nr = cr + dr[m]; nc = cc + dc[m];
					if (nr < 0 || nr > 7 || nc < 0 || nc > 7) continue;
					j = nr * 8 + nc;
					if (blocked[j] || closed[j]) continue;
					if (!opened[j] || ng < g[j]) begin
						opened[j] = 1; g[j] = ng; par[j] = best;
					end
				end
			end
			push_not_found();
		endfunction

		// compare one accepted output transaction with the oldest pending cell
		function void check_output(logic [31:0] d, logic tl);
			path_cell_t want;
			path_cell_t got;
			got.path_row = d[2:0];
			got.path_col = d[5:3];
			got.found = d[6];
			got.path_length = d[13:7];
			got.bid = d[27:14];
			got.last = tl;
			if (pending_cells.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected path cell r%0d c%0d", got.path_row, got.path_col);
				return;
			end
			want = pending_cells.pop_front();
			if (got !== want || d[31:28] !== 4'b0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want r%0d c%0d f%0d l%0d len%0d bid%0d, got r%0d c%0d f%0d l%0d len%0d bid%0d",
						want.path_row, want.path_col, want.found, want.last,
						want.path_length, want.bid, got.path_row, got.path_col,
						got.found, got.last, got.path_length, got.bid);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // row, col, obstacle, goal_row, goal_col
	logic        s_axis_tuser;   // operation
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // path_row, path_col, found, path_length, bid
	logic        m_axis_tlast;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;

	path_scoreboard sb;
	int          send_idle_pct;  // sender gap chance in percent
	int          recv_stall_pct; // receiver stall chance in percent
	int          hold_off_cycles;
	longint      cycle_count;

	grid_astar_path_search_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("[grid_astar_path_search_unit] ERROR");
			$finish;
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// sample output transactions at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tdata, m_axis_tlast);
	end

	function automatic logic [15:0] pack_item(logic [2:0] r, logic [2:0] c,
			logic obs, logic [2:0] gr, logic [2:0] gc);
		return {3'b0, gc, gr, obs, c, r};
	endfunction

	// offer one input transaction, with a random leading gap
	task automatic send_item(logic op, logic [15:0] d);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, d);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_cells.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_cost(logic [7:0] v);
		drain();
		repeat (8) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.move_cost = v;
	endtask

	task automatic load_cell(int r, int c, bit obs);
		send_item(gaps_pkg::OP_LOAD,
			pack_item(3'(r), 3'(c), obs, 3'($urandom), 3'($urandom)));
	endtask

	task automatic search(int sr, int sc, int gr, int gc);
		send_item(gaps_pkg::OP_SEARCH,
			pack_item(3'(sr), 3'(sc), 1'($urandom), 3'(gr), 3'(gc)));
	endtask

	// random grid with a given obstacle density, then a few searches
	task automatic random_round(int density, int searches);
		for (int i = 0; i < 64; i++)
			if (sb.blocked[i] != ($urandom_range(99) < density) || $urandom_range(15) == 0)
				load_cell(i / 8, i % 8, ($urandom_range(99) < density));
		for (int k = 0; k < searches; k++)
			search($urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		cycle_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset cost, open grid corner to corner and start equals goal
		search(0, 0, 7, 7);
		search(7, 7, 0, 0);
		search(3, 4, 3, 4);
		// wall in column 3 with one gap in row 7, load to every row
		for (int r = 0; r < 8; r++) load_cell(r, 3, (r != 7));
		search(0, 0, 0, 7);
		load_cell(7, 3, 1);             // closes the wall: no path
		search(0, 0, 0, 7);
		load_cell(0, 0, 1);             // blocked start still searched
		search(0, 0, 5, 2);
		search(5, 2, 0, 0);             // blocked goal
		search(0, 0, 0, 0);             // blocked start equals goal
		write_cost(8'd255);
		search(7, 0, 0, 2);
		write_cost(8'd0);
		search(6, 6, 1, 5);
		for (int r = 0; r < 8; r++) load_cell(r, 3, 0);
		load_cell(0, 0, 0);
		write_cost(8'd37);

		// random phases, each with its own idling mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			random_round(20, 6);
			if (ph == 2) begin
				// long receiver hold-off while searches keep coming
				@(negedge clk);
				hold_off_cycles = 3000;
				for (int k = 0; k < 6; k++) search($urandom, $urandom, $urandom, $urandom);
			end
			drain();
			write_cost(8'($urandom));
		end
		send_idle_pct = 0; recv_stall_pct = 0;
		write_cost(8'd1);
		random_round(0, 4);

		drain();
		repeat (200) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending_cells.size() == 0) begin
			$display("[grid_astar_path_search_unit] OK");
		end else begin
			$display("[grid_astar_path_search_unit] ERROR");
		end
		$finish;
	end

endmodule
